/* hdl/http_response_head_parser_defines.svh */
// ----------------------------------------------------------------------------
// HTTP response head parser assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEAD_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEAD_PARSER_DEFINES_SVH

// check post in the same cycle as pre
`define HRP_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("hrp check failed");

// check post in the cycle after pre
`define HRP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("hrp check failed");

`endif

/* hdl/hrp_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP response head parser package
// Widths, character codes, outcome codes, keyword tables and the result beat.
// ----------------------------------------------------------------------------
package hrp_pkg;

	// sizing
	localparam int LENGTH_BITS     = 32;
	localparam int HEAD_COUNT_BITS = 16;

	localparam logic [15:0] HEAD_LIMIT_RESET = 16'd4096;

	// characters
	localparam logic [7:0] CHAR_SP    = 8'h20;
	localparam logic [7:0] CHAR_HT    = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// keyword lengths
	localparam logic [3:0] VERSION_LEN = 4'd8;
	localparam logic [3:0] CL_LEN      = 4'd14;

	// outcome codes
	localparam logic [1:0] ST_PROC   = 2'd0;
	localparam logic [1:0] ST_ACCEPT = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_BAD       = 2'd1;
	localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

	typedef struct packed {
		logic [1:0]  parse_status;
		logic [1:0]  error_kind;
		logic [15:0] status_code;
		logic [31:0] content_length;
		logic        body_valid;
		logic [7:0]  body_byte;
		logic        body_last;
	} report_t;

	// "HTTP/1.1"
	function automatic logic [7:0] version_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h48;
			4'd1: c = 8'h54;
			4'd2: c = 8'h54;
			4'd3: c = 8'h50;
			4'd4: c = 8'h2F;
			4'd5: c = 8'h31;
			4'd6: c = 8'h2E;
			4'd7: c = 8'h31;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "Content-Length"
	function automatic logic [7:0] cl_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:  c = 8'h43;
			4'd1:  c = 8'h6F;
			4'd2:  c = 8'h6E;
			4'd3:  c = 8'h74;
			4'd4:  c = 8'h65;
			4'd5:  c = 8'h6E;
			4'd6:  c = 8'h74;
			4'd7:  c = 8'h2D;
			4'd8:  c = 8'h4C;
			4'd9:  c = 8'h65;
			4'd10: c = 8'h6E;
			4'd11: c = 8'h67;
			4'd12: c = 8'h74;
			4'd13: c = 8'h68;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* hdl/hrp_intf.sv */
// ----------------------------------------------------------------------------
// HTTP response head parser channels
// Byte stream in and result report out, each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrp_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface hrp_report_if;
	logic        valid;
	logic        ready;
	logic [1:0]  parse_status;
	logic [1:0]  error_kind;
	logic [15:0] status_code;
	logic [31:0] content_length;
	logic        body_valid;
	logic [7:0]  body_byte;
	logic        body_last;

	modport source (output valid, output parse_status, output error_kind,
		output status_code, output content_length, output body_valid,
		output body_byte, output body_last, input ready);
	modport sink (input valid, input parse_status, input error_kind,
		input status_code, input content_length, input body_valid,
		input body_byte, input body_last, output ready);
endinterface

/* hdl/hrp_in_stage.sv */
// ----------------------------------------------------------------------------
// HTTP response head parser input stage
// Registers one stream beat; frees itself when the core takes the byte.
// ----------------------------------------------------------------------------
module hrp_in_stage (
	input  logic         clk,
	input  logic         arst_n,
	hrp_stream_if.sink   stream,
	input  logic         take,
	output logic         valid_s1,
	output logic [7:0]   byte_s1
);

	logic accept;

	// accept when empty or when the held byte moves on this cycle
	assign stream.ready = !valid_s1 || take;
	assign accept       = stream.valid && stream.ready;

	// hold occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture the byte
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= stream.data_byte;
		end
	end

endmodule

/* hdl/hrp_parse_core.sv */
// ----------------------------------------------------------------------------
// HTTP response head parser core
// Parse state, limit register and the next-state logic for one byte.
// ----------------------------------------------------------------------------
`include "http_response_head_parser_defines.svh"

module hrp_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                step,
	input  logic [7:0]          byte_s1,
	output hrp_pkg::report_t    res_d
);

	localparam int ACC_W = hrp_pkg::LENGTH_BITS;
	localparam int NUM_W = hrp_pkg::LENGTH_BITS + 4;
	localparam int HC_W  = hrp_pkg::HEAD_COUNT_BITS;

	// phase codes
	localparam logic [2:0] PH_VERSION = 3'd0;
	localparam logic [2:0] PH_STATUS  = 3'd1;
	localparam logic [2:0] PH_REASON  = 3'd2;
	localparam logic [2:0] PH_HEADERS = 3'd3;
	localparam logic [2:0] PH_BODY    = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;

	// line flag positions
	localparam int F_IN_VALUE = 0;
	localparam int F_KEY      = 1;
	localparam int F_WS       = 2;
	localparam int F_DIGITS   = 3;
	localparam int F_BAD      = 4;
	localparam int F_NONEMPTY = 5;

	typedef struct packed {
		logic [3:0]       idx;
		logic             match;
		logic [5:0]       flags;
		logic [ACC_W-1:0] accum;
	} tok_t;

	localparam tok_t TOK_CLEAR = '{idx: 4'd0, match: 1'b1, flags: 6'd0, accum: '0};

	logic [15:0]        head_limit_q;
	logic [2:0]         phase_q, phase_d;
	logic [1:0]         outcome_q, outcome_d;
	logic [1:0]         kind_q, kind_d;
	logic               seen_cr_q, seen_cr_d;
	logic [HC_W-1:0]    head_count_q, head_count_d;
	tok_t               tok_q, tok_d, tok_pre;
	logic [15:0]        code_q, code_d;
	logic [ACC_W-1:0]   length_q, length_d;
	logic [ACC_W-1:0]   body_count_q, body_count_d;
	logic [NUM_W-1:0]   num10;
	logic [ACC_W:0]     body_next;
	logic               is_digit;
	logic               bv, bl;

	// advance the keyword compare by one character
	function automatic tok_t tok_advance(input tok_t t, input logic hit);
		tok_t r;
		r = t;
		if (!hit) begin
			r.match = 1'b0;
		end
		if (r.idx != 4'd15) begin
			r.idx = r.idx + 4'd1;
		end
		return r;
	endfunction

	// fold one header line byte into the token state
	function automatic tok_t hdr_content(input tok_t t, input logic [7:0] b,
		input logic [NUM_W-1:0] n10);
		tok_t r;
		logic ws;
		logic dig;
		logic hit;
		r   = t;
		ws  = (b == hrp_pkg::CHAR_SP) || (b == hrp_pkg::CHAR_HT);
		dig = (b >= hrp_pkg::CHAR_ZERO) && (b <= hrp_pkg::CHAR_NINE);
		hit = (t.idx < hrp_pkg::CL_LEN) && (b == hrp_pkg::cl_char(t.idx));
		r.flags[F_NONEMPTY] = 1'b1;
		if (!r.flags[F_IN_VALUE]) begin
			if (b == hrp_pkg::CHAR_COLON) begin
				r.flags[F_IN_VALUE] = 1'b1;
				r.flags[F_WS]       = 1'b0;
			end else if (ws) begin
				if (r.flags[F_KEY]) begin
					r.flags[F_WS] = 1'b1;
				end
			end else begin
				if (r.flags[F_WS]) begin
					r.match = 1'b0;
				end
				r.flags[F_KEY] = 1'b1;
				r.flags[F_WS]  = 1'b0;
				r = tok_advance(r, hit);
			end
		end else begin
			if (ws) begin
				if (r.flags[F_DIGITS]) begin
					r.flags[F_WS] = 1'b1;
				end
			end else if (dig && !r.flags[F_WS]) begin
				if (n10[NUM_W-1:ACC_W] != '0) begin
					r.flags[F_BAD] = 1'b1;
				end else begin
					r.accum           = n10[ACC_W-1:0];
					r.flags[F_DIGITS] = 1'b1;
				end
			end else begin
				r.flags[F_BAD] = 1'b1;
			end
		end
		return r;
	endfunction

	// accumulator times ten plus the digit in the current byte
	assign num10 = ({4'd0, tok_q.accum} << 3) + ({4'd0, tok_q.accum} << 1)
		+ NUM_W'(byte_s1[3:0]);
	assign is_digit  = (byte_s1 >= hrp_pkg::CHAR_ZERO) && (byte_s1 <= hrp_pkg::CHAR_NINE);
	assign body_next = {1'b0, body_count_q} + {{ACC_W{1'b0}}, 1'b1};

	// a pending CR that is not part of CRLF counts as line content first
	assign tok_pre = seen_cr_q ? hdr_content(tok_q, hrp_pkg::CHAR_CR, num10) : tok_q;

	// next state for the byte in the input register
	always_comb begin
		phase_d      = phase_q;
		outcome_d    = outcome_q;
		kind_d       = kind_q;
		seen_cr_d    = seen_cr_q;
		head_count_d = head_count_q;
		tok_d        = tok_q;
		code_d       = code_q;
		length_d     = length_q;
		body_count_d = body_count_q;
		bv           = 1'b0;
		bl           = 1'b0;

		if (outcome_q == hrp_pkg::ST_PROC) begin
			if (phase_q == PH_BODY) begin
				bv           = 1'b1;
				body_count_d = body_next[ACC_W-1:0];
				if (body_next >= {1'b0, length_q}) begin
					bl        = 1'b1;
					outcome_d = hrp_pkg::ST_ACCEPT;
					kind_d    = hrp_pkg::ERR_NONE;
					phase_d   = PH_DONE;
				end
			end else if (phase_q != PH_DONE) begin
				if (32'(head_count_q) >= 32'(head_limit_q)) begin
					outcome_d = hrp_pkg::ST_REJECT;
					kind_d    = hrp_pkg::ERR_TOO_LARGE;
					phase_d   = PH_DONE;
				end else begin
					if (head_count_q != '1) begin
						head_count_d = head_count_q + HC_W'(1);
					end
					case (phase_q)
						PH_VERSION: begin
							if (byte_s1 == hrp_pkg::CHAR_SP) begin
								if (tok_q.match && tok_q.idx == hrp_pkg::VERSION_LEN) begin
									phase_d = PH_STATUS;
									tok_d   = TOK_CLEAR;
								end else begin
									outcome_d = hrp_pkg::ST_REJECT;
									kind_d    = hrp_pkg::ERR_BAD;
									phase_d   = PH_DONE;
								end
							end else begin
								tok_d = tok_advance(tok_q,
									(tok_q.idx < hrp_pkg::VERSION_LEN) &&
									(byte_s1 == hrp_pkg::version_char(tok_q.idx)));
							end
						end
						PH_STATUS: begin
							if (byte_s1 == hrp_pkg::CHAR_SP) begin
								if (tok_q.flags[F_DIGITS] && !tok_q.flags[F_BAD]) begin
									code_d    = 16'(tok_q.accum);
									phase_d   = PH_REASON;
									seen_cr_d = 1'b0;
									tok_d     = TOK_CLEAR;
								end else begin
									outcome_d = hrp_pkg::ST_REJECT;
									kind_d    = hrp_pkg::ERR_BAD;
									phase_d   = PH_DONE;
								end
							end else if (is_digit) begin
								if (num10 > NUM_W'(16'hFFFF)) begin
									tok_d.flags[F_BAD] = 1'b1;
								end else begin
									tok_d.accum           = num10[ACC_W-1:0];
									tok_d.flags[F_DIGITS] = 1'b1;
								end
							end else begin
								tok_d.flags[F_BAD] = 1'b1;
							end
						end
						PH_REASON: begin
							if (seen_cr_q && byte_s1 == hrp_pkg::CHAR_LF) begin
								phase_d   = PH_HEADERS;
								seen_cr_d = 1'b0;
								tok_d     = TOK_CLEAR;
							end else begin
								seen_cr_d = (byte_s1 == hrp_pkg::CHAR_CR);
							end
						end
						default: begin
							if (seen_cr_q && byte_s1 == hrp_pkg::CHAR_LF) begin
								// end of line: a blank line opens the body, or accepts when the length is zero
								seen_cr_d = 1'b0;
								tok_d     = TOK_CLEAR;
								if (!tok_q.flags[F_NONEMPTY]) begin
									if (length_q == '0) begin
										outcome_d = hrp_pkg::ST_ACCEPT;
										kind_d    = hrp_pkg::ERR_NONE;
										phase_d   = PH_DONE;
									end else begin
										phase_d      = PH_BODY;
										body_count_d = '0;
									end
								end else if (tok_q.flags[F_KEY] && tok_q.match &&
									tok_q.idx == hrp_pkg::CL_LEN) begin
									if (tok_q.flags[F_DIGITS] && !tok_q.flags[F_BAD]) begin
										length_d = tok_q.accum;
									end else begin
										outcome_d = hrp_pkg::ST_REJECT;
										kind_d    = hrp_pkg::ERR_BAD;
										phase_d   = PH_DONE;
									end
								end else if (!tok_q.flags[F_KEY]) begin
									outcome_d = hrp_pkg::ST_REJECT;
									kind_d    = hrp_pkg::ERR_BAD;
									phase_d   = PH_DONE;
								end
							end else if (byte_s1 == hrp_pkg::CHAR_CR) begin
								seen_cr_d = 1'b1;
								tok_d     = tok_pre;
							end else begin
								seen_cr_d = 1'b0;
								tok_d     = hdr_content(tok_pre, byte_s1, num10);
							end
						end
					endcase
				end
			end
		end

		res_d.parse_status   = outcome_d;
		res_d.error_kind     = kind_d;
		res_d.status_code    = code_d;
		res_d.content_length = 32'(length_d);
		res_d.body_valid     = bv;
		res_d.body_byte      = bv ? byte_s1 : 8'd0;
		res_d.body_last      = bl;
	end

	// hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_limit_q <= hrp_pkg::HEAD_LIMIT_RESET;
		end else if (cfg_we) begin
			head_limit_q <= cfg_wdata;
		end
	end

	// advance the parse state once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_VERSION;
			outcome_q    <= hrp_pkg::ST_PROC;
			kind_q       <= hrp_pkg::ERR_NONE;
			seen_cr_q    <= 1'b0;
			head_count_q <= '0;
			tok_q        <= TOK_CLEAR;
			code_q       <= '0;
			length_q     <= '0;
			body_count_q <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			outcome_q    <= outcome_d;
			kind_q       <= kind_d;
			seen_cr_q    <= seen_cr_d;
			head_count_q <= head_count_d;
			tok_q        <= tok_d;
			code_q       <= code_d;
			length_q     <= length_d;
			body_count_q <= body_count_d;
		end
	end

	// a final outcome never changes
	`HRP_ASSERT_NEXT(a_final_holds, outcome_q != hrp_pkg::ST_PROC, $stable(outcome_q) && $stable(kind_q))
	// an error kind goes with a rejection only
	`HRP_ASSERT_NOW(a_kind_matches, 1'b1, (outcome_q == hrp_pkg::ST_REJECT) == (kind_q != hrp_pkg::ERR_NONE))
	// the last mark only on a body byte in the body phase
	`HRP_ASSERT_NOW(a_last_in_body, res_d.body_last, res_d.body_valid && phase_q == PH_BODY)
	// the body opens only with a nonzero length
	`HRP_ASSERT_NEXT(a_body_len, step && phase_q == PH_HEADERS && phase_d == PH_BODY, length_q != '0)

endmodule

/* hdl/hrp_out_stage.sv */
// ----------------------------------------------------------------------------
// HTTP response head parser output stage
// Result register driving the report channel.
// ----------------------------------------------------------------------------
module hrp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  hrp_pkg::report_t   res_d,
	input  logic               load,
	output logic               free,
	hrp_report_if.source       report
);

	hrp_pkg::report_t res_s2;
	logic             valid_s2;

	// room for a new result when empty or when the held one is taken
	assign free = !valid_s2 || report.ready;

	// hold occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (report.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// capture the result
	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_d;
		end
	end

	assign report.valid          = valid_s2;
	assign report.parse_status   = res_s2.parse_status;
	assign report.error_kind     = res_s2.error_kind;
	assign report.status_code    = res_s2.status_code;
	assign report.content_length = res_s2.content_length;
	assign report.body_valid     = res_s2.body_valid;
	assign report.body_byte      = res_s2.body_byte;
	assign report.body_last      = res_s2.body_last;

endmodule

/* hdl/http_response_head_parser.sv */
// ----------------------------------------------------------------------------
// HTTP response head parser
// Checks an HTTP/1.1 status line and headers, extracts status code and
// Content-Length, then passes the body bytes through and marks the last one.
//
//   channel   dir   beat payload
//   stream    in    data_byte
//   report    out   parse_status, error_kind, status_code, content_length,
//                   body_valid, body_byte, body_last
//   cfg       in    head_limit write (cfg_we, cfg_wdata)
//
// One byte per cycle sustained while the report side is ready; a report beat
// passes the input register, then the result register, after its stream beat.
// The cycle is set by the multiply-by-ten accumulate and keyword compares
// between the input register and the state and result registers.
// arst_n clears the parse state; the head limit returns to 4096.
// A stalled report holds its beat; one more stream beat is still taken
// into the input register behind it.
// ----------------------------------------------------------------------------
module http_response_head_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	hrp_stream_if.sink    stream,
	hrp_report_if.source  report
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             free;
	logic             step;
	hrp_pkg::report_t res_d;

	// move the held byte through the core when the result register has room
	assign step = valid_s1 && free;

	hrp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.take     (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	hrp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.byte_s1   (byte_s1),
		.res_d     (res_d)
	);

	hrp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.res_d  (res_d),
		.load   (step),
		.free   (free),
		.report (report)
	);

endmodule

/* tb/http_head_checker.sv */
// ----------------------------------------------------------------------------
// HTTP response head parser checker
// Runs every accepted stream beat through a cycle-free copy of the parser,
// queues the report beat it should produce and compares each report beat,
// field by field and in order, with the oldest one waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module http_head_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	hrp_stream_if       stream,
	hrp_report_if       report,
	output int          outstanding,
	output int          fail_count
);

	typedef enum logic [2:0] {
		PH_VERSION,
		PH_STATUS,
		PH_REASON,
		PH_HEADERS,
		PH_BODY,
		PH_DONE
	} phase_e;

	localparam int LEN_BITS   = hrp_pkg::LENGTH_BITS;
	localparam int ACC_BITS   = hrp_pkg::LENGTH_BITS + 1;
	localparam int COUNT_BITS = hrp_pkg::HEAD_COUNT_BITS;

	localparam logic [111:0] VERSION_TEXT = "HTTP/1.1";
	localparam logic [111:0] CL_TEXT      = "Content-Length";
	localparam longint unsigned LENGTH_MAX = (64'd1 << LEN_BITS) - 64'd1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// parser state
	phase_e                     phase;
	logic [1:0]                 outcome;
	logic [1:0]                 reject_kind;
	logic                       seen_cr;
	logic [COUNT_BITS-1:0]      head_count;
	logic [15:0]                head_limit;
	logic [3:0]                 tok_idx;
	logic                       tok_ok;
	logic                       in_value;
	logic                       has_key;
	logic                       ws_gap;
	logic                       has_digits;
	logic                       bad_field;
	logic                       nonempty;
	logic [ACC_BITS-1:0]        accum;
	logic [15:0]                code;
	logic [LEN_BITS-1:0]        length;
	logic [31:0]                body_count;

	hrp_pkg::report_t expected_q[$];

	function automatic void clear_token();
		tok_idx = '0;
		tok_ok = 1'b1;
		{in_value, has_key, ws_gap, has_digits, bad_field, nonempty} = '0;
		accum = '0;
	endfunction

	function automatic void close_response(input logic [1:0] st, input logic [1:0] err);
		outcome = st;
		reject_kind = err;
		phase = PH_DONE;
	endfunction

	function automatic void reset_parser();
		head_limit = hrp_pkg::HEAD_LIMIT_RESET;
		phase = PH_VERSION;
		outcome = hrp_pkg::ST_PROC;
		reject_kind = hrp_pkg::ERR_NONE;
		seen_cr = 1'b0;
		head_count = '0;
		clear_token();
		code = '0;
		length = '0;
		body_count = '0;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == hrp_pkg::CHAR_SP || b == hrp_pkg::CHAR_HT;
	endfunction

	// accumulate one decimal digit, flag the field once it would pass max
	function automatic void add_digit(input logic [7:0] b, input longint unsigned max);
		longint unsigned d;
		d = 64'(b - hrp_pkg::CHAR_ZERO);
		if (accum > (max - d) / 10) begin
			bad_field = 1'b1;
		end else begin
			accum = ACC_BITS'(accum * 10 + d);
			has_digits = 1'b1;
		end
	endfunction

	// compare against the keyword, text is right-aligned with len characters
	function automatic void match_char(input logic [111:0] text, input logic [3:0] len,
		input logic [7:0] b);
		int pos;
		pos = int'(len) - 1 - int'(tok_idx);
		if (tok_idx >= len) begin
			tok_ok = 1'b0;
		end else if (b != text[8*pos +: 8]) begin
			tok_ok = 1'b0;
		end
		if (tok_idx < 4'd15)
			tok_idx++;
	endfunction

	function automatic void header_content(input logic [7:0] b);
		nonempty = 1'b1;
		if (!in_value) begin
			if (b == hrp_pkg::CHAR_COLON) begin
				in_value = 1'b1;
				ws_gap = 1'b0;
			end else if (is_blank(b)) begin
				if (has_key)
					ws_gap = 1'b1;
			end else begin
				// blanks inside the key break the keyword match
				if (ws_gap)
					tok_ok = 1'b0;
				has_key = 1'b1;
				ws_gap = 1'b0;
				match_char(CL_TEXT, hrp_pkg::CL_LEN, b);
			end
		end else begin
			if (is_blank(b)) begin
				if (has_digits)
					ws_gap = 1'b1;
			end else if (b >= hrp_pkg::CHAR_ZERO && b <= hrp_pkg::CHAR_NINE && !ws_gap) begin
				add_digit(b, LENGTH_MAX);
			end else begin
				bad_field = 1'b1;
			end
		end
	endfunction

	function automatic void end_line();
		if (!nonempty) begin
			// blank line closes the head
			if (length == '0) begin
				close_response(hrp_pkg::ST_ACCEPT, hrp_pkg::ERR_NONE);
			end else begin
				phase = PH_BODY;
				body_count = '0;
			end
		end else if (has_key && tok_ok && tok_idx == hrp_pkg::CL_LEN) begin
			if (has_digits && !bad_field)
				length = accum[LEN_BITS-1:0];
			else
				close_response(hrp_pkg::ST_REJECT, hrp_pkg::ERR_BAD);
		end else if (!has_key) begin
			close_response(hrp_pkg::ST_REJECT, hrp_pkg::ERR_BAD);
		end
		clear_token();
	endfunction

	function automatic void head_byte(input logic [7:0] b);
		case (phase)
			PH_VERSION: begin
				if (b == hrp_pkg::CHAR_SP) begin
					if (tok_ok && tok_idx == hrp_pkg::VERSION_LEN) begin
						phase = PH_STATUS;
						clear_token();
					end else begin
						close_response(hrp_pkg::ST_REJECT, hrp_pkg::ERR_BAD);
					end
				end else begin
					match_char(VERSION_TEXT, hrp_pkg::VERSION_LEN, b);
				end
			end
			PH_STATUS: begin
				if (b == hrp_pkg::CHAR_SP) begin
					if (has_digits && !bad_field) begin
						code = accum[15:0];
						phase = PH_REASON;
						seen_cr = 1'b0;
						clear_token();
					end else begin
						close_response(hrp_pkg::ST_REJECT, hrp_pkg::ERR_BAD);
					end
				end else if (b >= hrp_pkg::CHAR_ZERO && b <= hrp_pkg::CHAR_NINE) begin
					add_digit(b, 64'd65535);
				end else begin
					bad_field = 1'b1;
				end
			end
			PH_REASON: begin
				if (seen_cr && b == hrp_pkg::CHAR_LF) begin
					phase = PH_HEADERS;
					seen_cr = 1'b0;
					clear_token();
				end else begin
					seen_cr = (b == hrp_pkg::CHAR_CR);
				end
			end
			default: begin
				// a CR only ends the line when LF follows, else it is content
				if (seen_cr) begin
					if (b == hrp_pkg::CHAR_LF) begin
						seen_cr = 1'b0;
						end_line();
					end else begin
						header_content(hrp_pkg::CHAR_CR);
						if (b == hrp_pkg::CHAR_CR) begin
							seen_cr = 1'b1;
						end else begin
							seen_cr = 1'b0;
							header_content(b);
						end
					end
				end else if (b == hrp_pkg::CHAR_CR) begin
					seen_cr = 1'b1;
				end else begin
					header_content(b);
				end
			end
		endcase
	endfunction

	// advance the parser by one stream byte and build the report it causes
	function automatic hrp_pkg::report_t parse_byte(input logic [7:0] b);
		hrp_pkg::report_t r;
		r.body_valid = 1'b0;
		r.body_byte = '0;
		r.body_last = 1'b0;
		if (outcome == hrp_pkg::ST_PROC) begin
			if (phase == PH_BODY) begin
				r.body_valid = 1'b1;
				r.body_byte = b;
				body_count++;
				if (body_count >= length) begin
					r.body_last = 1'b1;
					close_response(hrp_pkg::ST_ACCEPT, hrp_pkg::ERR_NONE);
				end
			end else if (phase != PH_DONE) begin
				if (head_count >= head_limit) begin
					close_response(hrp_pkg::ST_REJECT, hrp_pkg::ERR_TOO_LARGE);
				end else begin
					if (head_count != COUNT_MAX)
						head_count++;
					head_byte(b);
				end
			end
		end
		r.parse_status = outcome;
		r.error_kind = reject_kind;
		r.status_code = code;
		r.content_length = length[31:0];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		hrp_pkg::report_t want;
		if (!arst_n) begin
			reset_parser();
			expected_q.delete();
			outstanding <= 0;
		end else begin
			// pair each report beat with the oldest expected report
			if (report.valid && report.ready) begin
				if (expected_q.size() == 0) begin
					$error("report beat with no stream byte pending");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("parse_status", 32'(want.parse_status),
						32'(report.parse_status));
					check_field("error_kind", 32'(want.error_kind),
						32'(report.error_kind));
					check_field("status_code", 32'(want.status_code),
						32'(report.status_code));
					check_field("content_length", want.content_length,
						report.content_length);
					check_field("body_valid", 32'(want.body_valid),
						32'(report.body_valid));
					check_field("body_byte", 32'(want.body_byte),
						32'(report.body_byte));
					check_field("body_last", 32'(want.body_last),
						32'(report.body_last));
				end
			end
			if (cfg_we)
				head_limit = cfg_wdata;
			if (stream.valid && stream.ready)
				expected_q.push_back(parse_byte(stream.data_byte));
			outstanding <= expected_q.size();
		end
	end

endmodule

/* tb/tb_http_response_head_parser.sv */
// ----------------------------------------------------------------------------
// HTTP response head parser testbench
// Sends one response per run: a status line, header lines filling 800 to 1000
// head bytes with Content-Length entries and near misses, then one of several
// endings (body, empty body, bad header, oversized head, bad version or
// status) and ignored bytes after the end up to the run length. Both
// channels stall in random bursts; the head limit moves between header lines
// while the stream is held.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_http_response_head_parser;

	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEM_TARGET = 1250;

	typedef enum int {
		END_BAD_VERSION,
		END_BAD_STATUS,
		END_BAD_HEADER,
		END_TOO_LARGE,
		END_NO_BODY,
		END_WITH_BODY
	} ending_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          outstanding;
	int          fail_count;
	int          cycles = 0;
	int          sent_bytes = 0;
	bit          calm = 1'b0;
	bit          quiet = 1'b0;
	logic [7:0]  line_q[$];

	hrp_stream_if stream ();
	hrp_report_if report ();

	http_response_head_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stream    (stream),
		.report    (report)
	);

	http_head_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.stream      (stream),
		.report      (report),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endfunction

	function automatic void put_crlf();
		line_q.push_back(hrp_pkg::CHAR_CR);
		line_q.push_back(hrp_pkg::CHAR_LF);
	endfunction

	function automatic void put_blanks(input int most);
		repeat ($urandom_range(0, most))
			line_q.push_back($urandom_range(0, 1) ? hrp_pkg::CHAR_SP : hrp_pkg::CHAR_HT);
	endfunction

	// any byte but CR, so no line ends by accident
	function automatic logic [7:0] plain_char();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == hrp_pkg::CHAR_CR);
		return b;
	endfunction

	function automatic logic [7:0] key_char();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == hrp_pkg::CHAR_CR || b == hrp_pkg::CHAR_SP || b == hrp_pkg::CHAR_HT ||
			b == hrp_pkg::CHAR_COLON);
		return b;
	endfunction

	function automatic void put_key();
		repeat ($urandom_range(1, 10))
			line_q.push_back(key_char());
	endfunction

	function automatic void put_value();
		repeat ($urandom_range(0, 20))
			line_q.push_back(plain_char());
	endfunction

	// one stream beat, with an occasional idle burst ahead of it
	task automatic send_byte(input logic [7:0] b);
		if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
			stream.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		stream.valid <= 1'b1;
		stream.data_byte <= b;
		do @(posedge clk); while (!stream.ready);
		sent_bytes++;
		if ($urandom_range(0, 63) == 0)
			quiet = !quiet;
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_byte(line_q[i]);
		line_q.delete();
	endtask

	// hold the stream until every report is out, then write the limit
	task automatic set_head_limit(input logic [15:0] limit);
		stream.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		cfg_we <= 1'b1;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// report side stalls in bursts
	initial begin : report_pacing
		report.ready = 1'b0;
		@(posedge clk);
		forever begin
			report.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && !quiet && $urandom_range(0, 2) != 0) begin
				report.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		ending_e     ending;
		int          pick;
		int          head_target;
		int          next_cfg_at;
		int          body_len;
		logic [31:0] value;
		logic [7:0]  b;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		stream.valid = 1'b0;
		stream.data_byte = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_head_limit(16'hFFFF);

		pick = $urandom_range(0, 9);
		case (pick)
			0: ending = END_BAD_VERSION;
			1: ending = END_BAD_STATUS;
			2, 3: ending = END_BAD_HEADER;
			4: ending = END_TOO_LARGE;
			5: ending = END_NO_BODY;
			default: ending = END_WITH_BODY;
		endcase

		// status line
		if (ending == END_BAD_VERSION) begin
			case ($urandom_range(0, 4))
				0: put_text("HTTP/1.0");
				1: put_text("HTTP/1.11");
				2: put_text("http/1.1");
				3: put_text("HTTP/1.");
				default: ;
			endcase
			put_text(" 200 OK");
			put_crlf();
			put_crlf();
		end else begin
			put_text("HTTP/1.1 ");
			if (ending == END_BAD_STATUS) begin
				case ($urandom_range(0, 3))
					0: ;
					1: put_text("65536");
					2: put_text("2x0");
					default: put_text("1234567");
				endcase
			end else begin
				case ($urandom_range(0, 3))
					0: value = 65535;
					1: value = 0;
					default: value = $urandom_range(100, 599);
				endcase
				repeat ($urandom_range(0, 2)) put_text("0");
				put_text($sformatf("%0d", value));
			end
			put_text(" ");
			// reason phrase with a stray CR and a lone LF
			put_value();
			line_q.push_back(hrp_pkg::CHAR_CR);
			put_text("!");
			line_q.push_back(hrp_pkg::CHAR_LF);
			put_value();
			put_crlf();
		end
		send_line();

		// a bad version or status already closed the response
		if (ending != END_BAD_VERSION && ending != END_BAD_STATUS) begin
			// header lines
			head_target = $urandom_range(800, 1000);
			next_cfg_at = sent_bytes + $urandom_range(150, 350);
			while (sent_bytes < head_target) begin
				case ($urandom_range(0, 8))
					3: begin
						// no colon: the whole line is the key
						put_blanks(2);
						put_key();
						put_blanks(2);
						put_key();
						put_blanks(2);
					end
					4, 5: begin
						put_blanks(2);
						put_text("Content-Length");
						put_blanks(2);
						put_text(":");
						put_blanks(3);
						case ($urandom_range(0, 3))
							0: value = '0;
							1: value = '1;
							default: value = $urandom();
						endcase
						repeat ($urandom_range(0, 2)) put_text("0");
						put_text($sformatf("%0d", value));
						put_blanks(3);
					end
					6: begin
						// keys that must not count as Content-Length
						case ($urandom_range(0, 4))
							0: put_text("content-length");
							1: put_text("Content-Lengthy");
							2: put_text("Content-Lengt");
							3: put_text("Content -Length");
							default: put_text("Content-Length x");
						endcase
						put_text(": 1a 2");
						put_value();
					end
					7: begin
						// bare CR and lone LF inside the value
						put_key();
						put_text(":");
						put_value();
						line_q.push_back(hrp_pkg::CHAR_CR);
						do b = plain_char(); while (b == hrp_pkg::CHAR_LF);
						line_q.push_back(b);
						put_value();
						line_q.push_back(hrp_pkg::CHAR_LF);
						if ($urandom_range(0, 1))
							line_q.push_back(hrp_pkg::CHAR_CR);
					end
					8: begin
						put_key();
						put_blanks(4);
						put_text(":");
						put_blanks(4);
					end
					default: begin
						put_blanks(2);
						put_key();
						put_blanks(2);
						put_text(":");
						put_blanks(3);
						put_value();
					end
				endcase
				put_crlf();
				send_line();
				if (sent_bytes >= next_cfg_at) begin
					set_head_limit(16'($urandom_range(head_target + 400, 65535)));
					next_cfg_at = sent_bytes + $urandom_range(150, 350);
				end
			end

			// close the response
			case (ending)
				END_BAD_HEADER: begin
					calm = 1'b1;
					case ($urandom_range(0, 6))
						0: begin
							put_text(" ");
							put_blanks(3);
						end
						1: begin
							put_blanks(2);
							put_text(": value");
						end
						2: put_text("Content-Length: 4294967296");
						3: put_text("Content-Length: 12a");
						4: put_text("Content-Length:  ");
						5: put_text("Content-Length: 1 2");
						default: put_text("Content-Length: 099999999999");
					endcase
					put_crlf();
					send_line();
				end
				END_TOO_LARGE: begin
					calm = 1'b1;
					if ($urandom_range(0, 1))
						set_head_limit(16'd16);
					else
						set_head_limit(16'(sent_bytes + $urandom_range(0, 20)));
					put_text("X-Fill: ");
					repeat (40) line_q.push_back(plain_char());
					send_line();
				end
				default: begin
					body_len = (ending == END_WITH_BODY) ? $urandom_range(150, 350) : 0;
					put_text("Content-Length: ");
					repeat ($urandom_range(0, 2)) put_text("0");
					put_text($sformatf("%0d", body_len));
					put_crlf();
					put_crlf();
					// the last head byte lands exactly on the limit
					set_head_limit(16'(sent_bytes + line_q.size()));
					send_line();
					for (int i = 0; i < body_len; i++) begin
						if (i == body_len - 40)
							calm = 1'b1;
						send_byte(8'($urandom_range(0, 255)));
					end
					calm = 1'b1;
				end
			endcase
		end

		// bytes after the end are ignored; fill the run up to its length
		repeat ($urandom_range(3, 8))
			send_byte(8'($urandom_range(0, 255)));
		while (sent_bytes < ITEM_TARGET) begin
			if (sent_bytes >= ITEM_TARGET - 60)
				calm = 1'b1;
			send_byte(8'($urandom_range(0, 255)));
		end
		calm = 1'b1;
		stream.valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
